FILE: rtl/fps_pkg.sv
// shared types and constants for the flash protocol sniffer
package fps_pkg;

    localparam logic [1:0] PROTO_NONE  = 2'd0;
    localparam logic [1:0] PROTO_PAGE  = 2'd1;
    localparam logic [1:0] PROTO_SLIP  = 2'd2;
    localparam logic [1:0] PROTO_CMD   = 2'd3;

    localparam logic [7:0] PG_LOAD_ADDR  = 8'h55;
    localparam logic [7:0] PG_PROG_PAGE  = 8'h64;
    localparam logic [7:0] SLIP_END      = 8'hC0;
    localparam logic [7:0] SL_ESCAPE     = 8'hDB;
    localparam logic [7:0] SL_ESC_END    = 8'hDC;
    localparam logic [7:0] SL_ESC_ESC    = 8'hDD;
    localparam logic [7:0] SLIP_CMD_BEGIN = 8'h02;
    localparam logic [7:0] SLIP_CMD_DATA  = 8'h03;
    localparam logic [7:0] SLIP_CMD_SYNC  = 8'h08;
    localparam logic [7:0] CM_SYNC       = 8'h7F;
    localparam logic [7:0] CM_WRITE      = 8'h31;
    localparam logic [7:0] CM_ERASE      = 8'h43;
    localparam logic [7:0] CM_EXT_ERASE  = 8'h44;
    localparam logic [7:0] CM_GO         = 8'h21;
    localparam logic [7:0] CM_READ_PROT  = 8'h11;
    localparam logic [7:0] CM_COMP_MASK  = 8'hFF;
    localparam logic [31:0] FLASH_BASE   = 32'h0800_0000;

    localparam logic [6:0] PCT_MAX = 7'd100;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic load_out;
    } fps_cmd_t;

    typedef struct packed {
        logic div_busy;
    } fps_status_t;

endpackage

FILE: rtl/flash_protocol_sniffer.sv
// top level of the flash protocol sniffer
//
// channel   direction  ports
// s_        in         s_valid s_ready s_op s_data_byte
// m_        out        m_valid m_ready m_locked_protocol m_progress_percent
//
// the result is produced by the iterative percentage unit (3 scaling adds,
// 1 range check, 7 quotient bits); when the percentage is zero or capped
// early at the range check, the quotient bits are skipped
// items are taken one at a time, not before the last result is loaded; a waiting result
// does not stop the next item from being accepted and parsed, only its hand-off
// reset is synchronous and active low and clears all parser state but the slip header buffer
module flash_protocol_sniffer #(
    parameter int COUNT_WIDTH  = 32,
    parameter int HEADER_BYTES = 24
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_op,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_locked_protocol,
    output logic [6:0] m_progress_percent
);
    import fps_pkg::*;

    fps_cmd_t    cmd;
    fps_status_t status;

    fps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    fps_datapath #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_op     (s_op),
        .in_byte   (s_data_byte),
        .out_proto (m_locked_protocol),
        .out_pct   (m_progress_percent)
    );

endmodule

FILE: rtl/fps_div.sv
// iterative percentage unit: scales by 100, then restoring division with cap
module fps_div #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic                    zero,
    input  logic [COUNT_WIDTH+7:0]  w,
    input  logic [((COUNT_WIDTH+8 > 34) ? COUNT_WIDTH+8 : 34)-1:0] e,
    output logic                    busy,
    output logic [6:0]              quo
);
    import fps_pkg::*;

    localparam int WW = COUNT_WIDTH + 8;
    localparam int DW = (COUNT_WIDTH + 8 > 34) ? COUNT_WIDTH + 8 : 34;
    localparam int NW = COUNT_WIDTH + 15;
    localparam int XW = (NW > DW + 7) ? NW : DW + 7;

    localparam logic [3:0] STEP_MUL0  = 4'd0;
    localparam logic [3:0] STEP_MUL1  = 4'd1;
    localparam logic [3:0] STEP_MUL2  = 4'd2;
    localparam logic [3:0] STEP_CHECK = 4'd3;
    localparam logic [3:0] STEP_LAST  = 4'd10;

    logic          busy_reg, busy_next;
    logic [3:0]    step_reg, step_next;
    logic [XW-1:0] acc_reg, acc_next;
    logic [XW-1:0] dsh_reg, dsh_next;
    logic [WW-1:0] w_reg, w_next;
    logic [DW-1:0] d_reg, d_next;
    logic [6:0]    q_reg, q_next;
    logic          zero_reg, zero_next;

    logic [XW-1:0] wext, dext;
    logic [6:0]    q_shift;

    assign wext = {{(XW-WW){1'b0}}, w_reg};
    assign dext = {{(XW-DW){1'b0}}, d_reg};

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        acc_next  = acc_reg;
        dsh_next  = dsh_reg;
        w_next    = w_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        zero_next = zero_reg;
        q_shift   = {q_reg[5:0], 1'b0};
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_MUL0;
            acc_next  = '0;
            w_next    = w;
            d_next    = e;
            zero_next = zero;
            q_next    = '0;
        end else if (busy_reg) begin
            step_next = step_reg + 4'd1;
            case (step_reg)
                STEP_MUL0: acc_next = acc_reg + (wext << 6);
                STEP_MUL1: acc_next = acc_reg + (wext << 5);
                STEP_MUL2: acc_next = acc_reg + (wext << 2);
                STEP_CHECK: begin
                    if (zero_reg) begin
                        q_next    = '0;
                        busy_next = 1'b0;
                    end else if (acc_reg >= (dext << 7)) begin
                        q_next    = PCT_MAX;
                        busy_next = 1'b0;
                    end else begin
                        dsh_next = dext << 6;
                    end
                end
                default: begin
                    if (acc_reg >= dsh_reg) begin
                        acc_next = acc_reg - dsh_reg;
                        q_shift  = {q_reg[5:0], 1'b1};
                    end
                    dsh_next = dsh_reg >> 1;
                    q_next   = q_shift;
                    if (step_reg == STEP_LAST) begin
                        busy_next = 1'b0;
                        if (q_shift > PCT_MAX) begin
                            q_next = PCT_MAX;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= STEP_MUL0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
        acc_reg  <= acc_next;
        dsh_reg  <= dsh_next;
        w_reg    <= w_next;
        d_reg    <= d_next;
        q_reg    <= q_next;
        zero_reg <= zero_next;
    end

    assign busy = busy_reg;
    assign quo  = q_reg;

endmodule

FILE: rtl/fps_datapath.sv
// parser state, protocol lock, progress operands and result register
module fps_datapath #(
    parameter int COUNT_WIDTH  = 32,
    parameter int HEADER_BYTES = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fps_pkg::fps_cmd_t    cmd,
    output fps_pkg::fps_status_t status,
    input  logic                 in_op,
    input  logic [7:0]           in_byte,
    output logic [1:0]           out_proto,
    output logic [6:0]           out_pct
);
    import fps_pkg::*;

    localparam int WW = COUNT_WIDTH + 8;
    localparam int DW = (COUNT_WIDTH + 8 > 34) ? COUNT_WIDTH + 8 : 34;
    localparam int FW = $clog2(HEADER_BYTES + 1);
    localparam int IW = $clog2(HEADER_BYTES);

    localparam logic [2:0] PG_IDLE = 3'd0;
    localparam logic [2:0] PG_ALO  = 3'd1;
    localparam logic [2:0] PG_AHI  = 3'd2;
    localparam logic [2:0] PG_LHI  = 3'd3;
    localparam logic [2:0] PG_LLO  = 3'd4;
    localparam logic [2:0] PG_MODE = 3'd5;
    localparam logic [2:0] PG_SKIP = 3'd6;

    localparam logic [2:0] CM_IDLE  = 3'd0;
    localparam logic [2:0] CM_COMP  = 3'd1;
    localparam logic [2:0] CM_ADDR  = 3'd2;
    localparam logic [2:0] CM_COUNT = 3'd3;
    localparam logic [2:0] CM_DATA  = 3'd4;

    localparam logic [COUNT_WIDTH-1:0] CNT_FULL = '1;

    logic [1:0]             det_reg, det_next;
    logic [2:0]             pg_phase_reg, pg_phase_next;
    logic [7:0]             pg_held_reg, pg_held_next;
    logic [16:0]            pg_skip_reg, pg_skip_next;
    logic [COUNT_WIDTH-1:0] pg_count_reg, pg_count_next;
    logic [15:0]            pg_max_reg, pg_max_next;
    logic [7:0]             hdr_reg [HEADER_BYTES];
    logic                   hdr_we;
    logic [7:0]             hdr_wdata;
    logic [FW-1:0]          sl_fill_reg, sl_fill_next;
    logic                   sl_esc_reg, sl_esc_next;
    logic                   sl_in_reg, sl_in_next;
    logic [COUNT_WIDTH-1:0] sl_blocks_reg, sl_blocks_next;
    logic [31:0]            sl_total_reg, sl_total_next;
    logic [2:0]             cm_phase_reg, cm_phase_next;
    logic [7:0]             cm_code_reg, cm_code_next;
    logic [31:0]            cm_addr_reg, cm_addr_next;
    logic [2:0]             cm_abytes_reg, cm_abytes_next;
    logic [8:0]             cm_left_reg, cm_left_next;
    logic [31:0]            cm_rel_reg, cm_rel_next;
    logic [COUNT_WIDTH-1:0] cm_count_reg, cm_count_next;
    logic [1:0]             out_proto_reg;
    logic [6:0]             out_pct_reg;

    logic        pg_done, sl_lock, cm_lock;
    logic [1:0]  det_p, det_s;
    logic [15:0] pg_addr;
    logic [16:0] pg_skip_dec;
    logic [8:0]  cm_left_dec;
    logic [7:0]  sl_b;
    logic [31:0] cm_rel_new;

    always_comb begin
        det_next       = det_reg;
        pg_phase_next  = pg_phase_reg;
        pg_held_next   = pg_held_reg;
        pg_skip_next   = pg_skip_reg;
        pg_count_next  = pg_count_reg;
        pg_max_next    = pg_max_reg;
        sl_fill_next   = sl_fill_reg;
        sl_esc_next    = sl_esc_reg;
        sl_in_next     = sl_in_reg;
        sl_blocks_next = sl_blocks_reg;
        sl_total_next  = sl_total_reg;
        cm_phase_next  = cm_phase_reg;
        cm_code_next   = cm_code_reg;
        cm_addr_next   = cm_addr_reg;
        cm_abytes_next = cm_abytes_reg;
        cm_left_next   = cm_left_reg;
        cm_rel_next    = cm_rel_reg;
        cm_count_next  = cm_count_reg;
        hdr_we         = 1'b0;
        hdr_wdata      = in_byte;
        pg_done        = 1'b0;
        sl_lock        = 1'b0;
        cm_lock        = 1'b0;
        det_p          = det_reg;
        det_s          = det_reg;
        pg_addr        = {in_byte, pg_held_reg};
        pg_skip_dec    = (pg_skip_reg != 17'd0) ? pg_skip_reg - 17'd1 : 17'd0;
        cm_left_dec    = (cm_left_reg != 9'd0) ? cm_left_reg - 9'd1 : 9'd0;
        sl_b           = in_byte;
        cm_rel_new     = cm_addr_reg - FLASH_BASE;

        // page-program parser
        if (det_reg == PROTO_NONE || det_reg == PROTO_PAGE) begin
            case (pg_phase_reg)
                PG_IDLE: begin
                    if (in_byte == PG_LOAD_ADDR) begin
                        pg_phase_next = PG_ALO;
                    end else if (in_byte == PG_PROG_PAGE) begin
                        pg_phase_next = PG_LHI;
                    end
                end
                PG_ALO: begin
                    pg_held_next  = in_byte;
                    pg_phase_next = PG_AHI;
                end
                PG_AHI: begin
                    if (pg_addr > pg_max_reg) begin
                        pg_max_next = pg_addr;
                    end
                    pg_phase_next = PG_IDLE;
                    pg_done       = 1'b1;
                end
                PG_LHI: begin
                    pg_held_next  = in_byte;
                    pg_phase_next = PG_LLO;
                end
                PG_LLO: begin
                    pg_skip_next  = {1'b0, pg_held_reg, in_byte} + 17'd2;
                    pg_phase_next = PG_MODE;
                end
                PG_MODE: begin
                    pg_skip_next  = pg_skip_dec;
                    pg_phase_next = (pg_skip_dec != 17'd0) ? PG_SKIP : PG_IDLE;
                end
                PG_SKIP: begin
                    pg_skip_next = pg_skip_dec;
                    if (pg_skip_dec == 17'd0) begin
                        if (pg_count_reg != CNT_FULL) begin
                            pg_count_next = pg_count_reg + COUNT_WIDTH'(1);
                        end
                        pg_phase_next = PG_IDLE;
                        pg_done       = 1'b1;
                    end
                end
                default: pg_phase_next = PG_IDLE;
            endcase
            if (pg_done && det_reg == PROTO_NONE) begin
                det_p = PROTO_PAGE;
            end
        end
        det_s = det_p;

        // slip parser
        if (det_p == PROTO_NONE || det_p == PROTO_SLIP) begin
            if (in_byte == SLIP_END) begin
                if (sl_fill_reg >= FW'(8)) begin
                    if (hdr_reg[1] == 8'd0) begin
                        if (hdr_reg[2] == SLIP_CMD_BEGIN && sl_fill_reg >= FW'(24)) begin
                            sl_total_next = {hdr_reg[15], hdr_reg[14],
                                             hdr_reg[13], hdr_reg[12]};
                        end else if (hdr_reg[2] == SLIP_CMD_DATA) begin
                            if (sl_blocks_reg != CNT_FULL) begin
                                sl_blocks_next = sl_blocks_reg + COUNT_WIDTH'(1);
                            end
                        end
                    end
                    sl_lock = (hdr_reg[2] == SLIP_CMD_BEGIN) ||
                              (hdr_reg[2] == SLIP_CMD_DATA) ||
                              (hdr_reg[2] == SLIP_CMD_SYNC);
                end
                sl_fill_next = '0;
                sl_esc_next  = 1'b0;
                sl_in_next   = 1'b1;
            end else if (sl_in_reg) begin
                if (sl_esc_reg || in_byte != SL_ESCAPE) begin
                    if (sl_esc_reg) begin
                        if (in_byte == SL_ESC_END) begin
                            sl_b = SLIP_END;
                        end else if (in_byte == SL_ESC_ESC) begin
                            sl_b = SL_ESCAPE;
                        end
                    end
                    sl_esc_next = 1'b0;
                    if (sl_fill_reg < FW'(HEADER_BYTES)) begin
                        hdr_we       = 1'b1;
                        hdr_wdata    = sl_b;
                        sl_fill_next = sl_fill_reg + FW'(1);
                    end
                end else begin
                    sl_esc_next = 1'b1;
                end
            end
            if (sl_lock && det_p == PROTO_NONE) begin
                det_s = PROTO_SLIP;
            end
        end
        det_next = det_s;

        // complement-checked command parser
        if (det_s == PROTO_NONE || det_s == PROTO_CMD) begin
            case (cm_phase_reg)
                CM_IDLE: begin
                    if (in_byte == CM_SYNC) begin
                        cm_lock = 1'b1;
                    end else if (in_byte == CM_WRITE || in_byte == CM_ERASE ||
                                 in_byte == CM_EXT_ERASE || in_byte == CM_GO ||
                                 in_byte == CM_READ_PROT) begin
                        cm_code_next  = in_byte;
                        cm_phase_next = CM_COMP;
                    end
                end
                CM_COMP: begin
                    cm_phase_next = CM_IDLE;
                    if ((in_byte ^ cm_code_reg) == CM_COMP_MASK) begin
                        cm_lock = 1'b1;
                        if (cm_code_reg == CM_WRITE) begin
                            cm_addr_next   = '0;
                            cm_abytes_next = '0;
                            cm_phase_next  = CM_ADDR;
                        end
                    end
                end
                CM_ADDR: begin
                    if (cm_abytes_reg < 3'd4) begin
                        cm_addr_next   = {cm_addr_reg[23:0], in_byte};
                        cm_abytes_next = cm_abytes_reg + 3'd1;
                    end else begin
                        cm_phase_next = CM_COUNT;
                    end
                end
                CM_COUNT: begin
                    cm_left_next = {1'b0, in_byte} + 9'd2;
                    if (cm_addr_reg >= FLASH_BASE) begin
                        if (cm_rel_new > cm_rel_reg) begin
                            cm_rel_next = cm_rel_new;
                        end
                        if (cm_count_reg != CNT_FULL) begin
                            cm_count_next = cm_count_reg + COUNT_WIDTH'(1);
                        end
                    end
                    cm_phase_next = CM_DATA;
                end
                CM_DATA: begin
                    cm_left_next = cm_left_dec;
                    if (cm_left_dec == 9'd0) begin
                        cm_phase_next = CM_IDLE;
                    end
                end
                default: cm_phase_next = CM_IDLE;
            endcase
            if (cm_lock && det_s == PROTO_NONE) begin
                det_next = PROTO_CMD;
            end
        end

        if (in_op) begin
            det_next       = PROTO_NONE;
            pg_phase_next  = PG_IDLE;
            pg_held_next   = '0;
            pg_skip_next   = '0;
            pg_count_next  = '0;
            pg_max_next    = '0;
            sl_fill_next   = '0;
            sl_esc_next    = 1'b0;
            sl_in_next     = 1'b0;
            sl_blocks_next = '0;
            sl_total_next  = '0;
            cm_phase_next  = CM_IDLE;
            cm_code_next   = '0;
            cm_addr_next   = '0;
            cm_abytes_next = '0;
            cm_left_next   = '0;
            cm_rel_next    = '0;
            cm_count_next  = '0;
            hdr_we         = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            det_reg       <= PROTO_NONE;
            pg_phase_reg  <= PG_IDLE;
            pg_held_reg   <= '0;
            pg_skip_reg   <= '0;
            pg_count_reg  <= '0;
            pg_max_reg    <= '0;
            sl_fill_reg   <= '0;
            sl_esc_reg    <= 1'b0;
            sl_in_reg     <= 1'b0;
            sl_blocks_reg <= '0;
            sl_total_reg  <= '0;
            cm_phase_reg  <= CM_IDLE;
            cm_code_reg   <= '0;
            cm_addr_reg   <= '0;
            cm_abytes_reg <= '0;
            cm_left_reg   <= '0;
            cm_rel_reg    <= '0;
            cm_count_reg  <= '0;
        end else if (cmd.accept) begin
            det_reg       <= det_next;
            pg_phase_reg  <= pg_phase_next;
            pg_held_reg   <= pg_held_next;
            pg_skip_reg   <= pg_skip_next;
            pg_count_reg  <= pg_count_next;
            pg_max_reg    <= pg_max_next;
            sl_fill_reg   <= sl_fill_next;
            sl_esc_reg    <= sl_esc_next;
            sl_in_reg     <= sl_in_next;
            sl_blocks_reg <= sl_blocks_next;
            sl_total_reg  <= sl_total_next;
            cm_phase_reg  <= cm_phase_next;
            cm_code_reg   <= cm_code_next;
            cm_addr_reg   <= cm_addr_next;
            cm_abytes_reg <= cm_abytes_next;
            cm_left_reg   <= cm_left_next;
            cm_rel_reg    <= cm_rel_next;
            cm_count_reg  <= cm_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && hdr_we) begin
            hdr_reg[sl_fill_reg[IW-1:0]] <= hdr_wdata;
        end
    end

    // progress operands for the locked protocol
    logic [WW-1:0] div_w;
    logic [DW-1:0] div_e, est;
    logic          div_zero;
    logic [6:0]    div_q;

    always_comb begin
        div_w    = '0;
        est      = '0;
        div_zero = 1'b1;
        case (det_reg)
            PROTO_PAGE: begin
                div_w    = {1'b0, pg_count_reg, 7'd0};
                est      = DW'({pg_max_reg, 1'b0}) + DW'(2);
                div_zero = (pg_count_reg == '0);
            end
            PROTO_SLIP: begin
                div_w    = WW'(sl_blocks_reg);
                est      = DW'(sl_total_reg);
                div_zero = (sl_total_reg == 32'd0);
            end
            PROTO_CMD: begin
                div_w    = {cm_count_reg, 8'd0};
                est      = DW'({1'b0, cm_rel_reg, 1'b0}) + DW'(512);
                div_zero = (cm_count_reg == '0) || (cm_rel_reg == 32'd0);
            end
            default: div_zero = 1'b1;
        endcase
        div_e = est;
        if (det_reg != PROTO_SLIP && DW'(div_w) > est) begin
            div_e = DW'(div_w);
        end
    end

    fps_div #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .zero    (div_zero),
        .w       (div_w),
        .e       (div_e),
        .busy    (status.div_busy),
        .quo     (div_q)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_proto_reg <= det_reg;
            out_pct_reg   <= div_q;
        end
    end

    assign out_proto = out_proto_reg;
    assign out_pct   = out_pct_reg;

endmodule

FILE: rtl/fps_ctrl.sv
// controller state machine: accept, progress divide, hand-off to output
module fps_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output fps_pkg::fps_cmd_t    cmd,
    input  fps_pkg::fps_status_t status
);
    import fps_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_PUT   = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT: begin
                if (!status.div_busy) begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule
